// ===== hdl/fdrm_pkg.sv =====
// Shared definitions for the fixed-depth radix map core.
// Operation codes and the fixed port field widths; no dependencies.
package fdrm_pkg;

    localparam int unsigned OP_W        = 2;
    localparam int unsigned KEY_PORT_W  = 36;
    localparam int unsigned VAL_PORT_W  = 48;

    typedef enum logic [OP_W-1:0] {
        OP_GET    = 2'd0,
        OP_ADD    = 2'd1,
        OP_DELETE = 2'd2,
        OP_NONE   = 2'd3
    } op_t;

endpackage

// ===== hdl/fixed_depth_radix_map_core.sv =====
// A get reads and evaluates each level in turn, then registers its result on m_valid; an add
// or delete walks the upper levels alike and ends with one write at the leaf; the unused op
// code skips the walk; misses and pool exhaustion end sooner. One transaction at a time: the
// next input is taken the cycle after the result registers, even while it waits. Reset:
// aresetn (synchronous) starts a clearing pass over all POOL_NODES << NODE_BITS entries
// (32768 by default) that zeroes the node memory; s_ready stays low until done. Needs fdrm_pkg.
module fixed_depth_radix_map_core #(
    parameter int unsigned LEVEL_COUNT = 4,
    parameter int unsigned NODE_BITS   = 9,
    parameter int unsigned POOL_NODES  = 64,
    parameter int unsigned VALUE_BITS  = 48
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [fdrm_pkg::OP_W-1:0]         s_op,
    input  logic [fdrm_pkg::KEY_PORT_W-1:0]   s_key,
    input  logic [fdrm_pkg::VAL_PORT_W-1:0]   s_value,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic                              m_status,
    output logic                              m_found,
    output logic [fdrm_pkg::VAL_PORT_W-1:0]   m_read_value
);

    localparam int unsigned KEY_W     = LEVEL_COUNT * NODE_BITS;
    localparam int unsigned NODE_W    = $clog2(POOL_NODES);
    localparam int unsigned ADDR_W    = NODE_W + NODE_BITS;
    localparam int unsigned MEM_DEPTH = POOL_NODES << NODE_BITS;
    localparam int unsigned NF_W      = $clog2(POOL_NODES + 1);
    localparam int unsigned LVL_W     = $clog2(LEVEL_COUNT);
    localparam int unsigned KPW       = fdrm_pkg::KEY_PORT_W;
    localparam int unsigned VPW       = fdrm_pkg::VAL_PORT_W;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_LOOK,
        S_EVAL,
        S_DONE
    } state_t;

    logic [VALUE_BITS-1:0] mem [MEM_DEPTH];
    logic [VALUE_BITS-1:0] mem_rd_reg;

    state_t                state_reg;
    logic [ADDR_W-1:0]     clr_cnt_reg;
    logic [NF_W-1:0]       next_free_reg;
    fdrm_pkg::op_t         op_reg;
    logic [KEY_W-1:0]      key_sh_reg;
    logic [VALUE_BITS-1:0] val_reg;
    logic [NODE_W-1:0]     node_reg;
    logic [LVL_W-1:0]      level_reg;
    logic                  res_status_reg;
    logic                  res_found_reg;
    logic [VALUE_BITS-1:0] res_value_reg;
    logic                  m_valid_reg;
    logic                  m_status_reg;
    logic                  m_found_reg;
    logic [VPW-1:0]        m_read_value_reg;

    logic [KEY_W+KPW-1:0]        key_wide;
    logic [VALUE_BITS+VPW-1:0]   val_wide;
    logic [VPW+VALUE_BITS-1:0]   out_wide;
    logic [NODE_BITS-1:0]        slice;
    logic [ADDR_W-1:0]           walk_addr;
    logic                        link_ok;
    logic                        pool_full;
    logic                        is_store;
    logic                        mem_we;
    logic [ADDR_W-1:0]           mem_waddr;
    logic [VALUE_BITS-1:0]       mem_wdata;
    logic                        mem_re;

    assign key_wide  = {{KEY_W{1'b0}}, s_key};
    assign val_wide  = {{VALUE_BITS{1'b0}}, s_value};
    assign out_wide  = {{VPW{1'b0}}, res_value_reg};
    assign slice     = key_sh_reg[KEY_W-1 -: NODE_BITS];
    assign walk_addr = {node_reg, slice};
    assign link_ok   = (mem_rd_reg != '0) && (mem_rd_reg < VALUE_BITS'(POOL_NODES));
    assign pool_full = (next_free_reg == NF_W'(POOL_NODES));
    assign is_store  = (op_reg == fdrm_pkg::OP_ADD) || (op_reg == fdrm_pkg::OP_DELETE);

    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = walk_addr;
        mem_wdata = '0;
        mem_re    = 1'b0;
        unique case (state_reg)
            S_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = clr_cnt_reg;
            end
            S_LOOK: begin
                if (level_reg == '0 && is_store) begin
                    mem_we    = 1'b1;
                    mem_wdata = val_reg;
                end else begin
                    mem_re = 1'b1;
                end
            end
            S_EVAL: begin
                if (level_reg != '0 && !link_ok && is_store && !pool_full) begin
                    mem_we    = 1'b1;
                    mem_wdata = VALUE_BITS'(next_free_reg);
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            mem_rd_reg <= mem[walk_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_CLEAR;
            clr_cnt_reg   <= '0;
            next_free_reg <= NF_W'(1);
            m_valid_reg   <= 1'b0;
        end else begin
            if (m_valid_reg && m_ready && state_reg != S_DONE) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_CLEAR: begin
                    clr_cnt_reg <= clr_cnt_reg + ADDR_W'(1);
                    if (clr_cnt_reg == ADDR_W'(MEM_DEPTH - 1)) begin
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (s_valid) begin
                        op_reg         <= fdrm_pkg::op_t'(s_op);
                        key_sh_reg     <= key_wide[KEY_W-1:0];
                        val_reg        <= (s_op == fdrm_pkg::OP_ADD) ?
                                          val_wide[VALUE_BITS-1:0] : '0;
                        node_reg       <= '0;
                        level_reg      <= LVL_W'(LEVEL_COUNT - 1);
                        res_status_reg <= 1'b0;
                        res_found_reg  <= 1'b0;
                        res_value_reg  <= '0;
                        state_reg      <= (s_op == fdrm_pkg::OP_NONE) ? S_DONE : S_LOOK;
                    end
                end
                S_LOOK: begin
                    state_reg <= (level_reg == '0 && is_store) ? S_DONE : S_EVAL;
                end
                S_EVAL: begin
                    priority if (level_reg == '0) begin
                        res_found_reg <= (mem_rd_reg != '0);
                        res_value_reg <= mem_rd_reg;
                        state_reg     <= S_DONE;
                    end else if (link_ok) begin
                        node_reg   <= mem_rd_reg[NODE_W-1:0];
                        level_reg  <= level_reg - LVL_W'(1);
                        key_sh_reg <= key_sh_reg << NODE_BITS;
                        state_reg  <= S_LOOK;
                    end else if (!is_store) begin
                        state_reg <= S_DONE;
                    end else if (pool_full) begin
                        res_status_reg <= 1'b1;
                        state_reg      <= S_DONE;
                    end else begin
                        node_reg      <= next_free_reg[NODE_W-1:0];
                        next_free_reg <= next_free_reg + NF_W'(1);
                        level_reg     <= level_reg - LVL_W'(1);
                        key_sh_reg    <= key_sh_reg << NODE_BITS;
                        state_reg     <= S_LOOK;
                    end
                end
                S_DONE: begin
                    if (!m_valid_reg || m_ready) begin
                        m_valid_reg      <= 1'b1;
                        m_status_reg     <= res_status_reg;
                        m_found_reg      <= res_found_reg;
                        m_read_value_reg <= out_wide[VPW-1:0];
                        state_reg        <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_CLEAR;
                end
            endcase
        end
    end

    assign s_ready      = (state_reg == S_IDLE);
    assign m_valid      = m_valid_reg;
    assign m_status     = m_status_reg;
    assign m_found      = m_found_reg;
    assign m_read_value = m_read_value_reg;

`ifndef SYNTHESIS
    a_free_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (next_free_reg != '0) && (next_free_reg <= NF_W'(POOL_NODES)))
        else $error("free node counter out of range");

    a_get_no_alloc: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_EVAL && op_reg == fdrm_pkg::OP_GET) |=> $stable(next_free_reg))
        else $error("get allocated a node");

    a_clear_blocks: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_CLEAR) |-> (!s_ready && !mem_re))
        else $error("access during memory clear");

    a_status_store_only: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_DONE && res_status_reg) |-> (is_store && pool_full))
        else $error("error status without exhausted pool");
`endif

endmodule

// ===== tb/fdrm_map_checker.sv =====
// Checker for the fixed-depth radix map core: watches both channels, predicts each
// result from its own copy of the node pool and compares field by field.
// Depends on fdrm_pkg.
module fdrm_map_checker #(
    parameter int unsigned LEVEL_COUNT = 4,
    parameter int unsigned NODE_BITS   = 9,
    parameter int unsigned POOL_NODES  = 64
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    input  logic                            s_ready,
    input  logic [fdrm_pkg::OP_W-1:0]       s_op,
    input  logic [fdrm_pkg::KEY_PORT_W-1:0] s_key,
    input  logic [fdrm_pkg::VAL_PORT_W-1:0] s_value,
    input  logic                            m_valid,
    input  logic                            m_ready,
    input  logic                            m_status,
    input  logic                            m_found,
    input  logic [fdrm_pkg::VAL_PORT_W-1:0] m_read_value,
    output int unsigned                     mismatches,
    output int unsigned                     results_checked,
    output int unsigned                     lookup_hits,
    output int unsigned                     pool_full_stores,
    output int unsigned                     pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned SLOT_COUNT = POOL_NODES << NODE_BITS;
    localparam int unsigned KPW        = fdrm_pkg::KEY_PORT_W;
    localparam int unsigned VPW        = fdrm_pkg::VAL_PORT_W;

    typedef struct packed {
        logic           status;
        logic           found;
        logic [VPW-1:0] read_value;
    } map_result_t;

    logic [VPW-1:0] node_slots [SLOT_COUNT];
    int unsigned    next_free_node;
    map_result_t    expected_results [$];

    function automatic map_result_t step_map(fdrm_pkg::op_t op, logic [KPW-1:0] key,
                                             logic [VPW-1:0] value);
        map_result_t    res;
        int unsigned    node;
        int unsigned    addr;
        int             lvl;
        logic [VPW-1:0] link;
        res  = '0;
        node = 0;
        if (op == fdrm_pkg::OP_NONE) return res;
        for (lvl = LEVEL_COUNT - 1; lvl > 0; lvl--) begin
            addr = (node << NODE_BITS) | 32'(key[lvl*NODE_BITS +: NODE_BITS]);
            link = node_slots[addr];
            if (link == '0 || link >= POOL_NODES) begin
                if (op == fdrm_pkg::OP_GET) return res;
                if (next_free_node >= POOL_NODES) begin
                    res.status = 1'b1;
                    return res;
                end
                link = VPW'(next_free_node);
                next_free_node++;
                node_slots[addr] = link;
            end
            node = link[31:0];
        end
        addr = (node << NODE_BITS) | 32'(key[NODE_BITS-1:0]);
        if (op == fdrm_pkg::OP_GET) begin
            res.read_value = node_slots[addr];
            res.found      = (node_slots[addr] != '0);
        end else begin
            node_slots[addr] = (op == fdrm_pkg::OP_ADD) ? value : '0;
        end
        return res;
    endfunction

    task automatic report_field(string field, logic [VPW-1:0] want, logic [VPW-1:0] got);
        if (want !== got) begin
            mismatches++;
            $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h",
                     $time, field, want, got);
        end
    endtask

    always @(posedge aclk) begin
        map_result_t want;
        if (!aresetn) begin
            foreach (node_slots[i]) node_slots[i] = '0;
            next_free_node = 1;
            expected_results.delete();
            mismatches       = 0;
            results_checked  = 0;
            lookup_hits      = 0;
            pool_full_stores = 0;
            pending          = 0;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_results.size() == 0) begin
                    mismatches++;
                    $display({"%0t: unexpected result, expected none, ",
                              "actual status %0b found %0b value 0x%0h"},
                             $time, m_status, m_found, m_read_value);
                end else begin
                    want = expected_results.pop_front();
                    results_checked++;
                    report_field("status", VPW'(want.status), VPW'(m_status));
                    report_field("found", VPW'(want.found), VPW'(m_found));
                    report_field("read_value", want.read_value, m_read_value);
                end
            end
            if (s_valid && s_ready) begin
                want = step_map(fdrm_pkg::op_t'(s_op), s_key, s_value);
                if (want.found) lookup_hits++;
                if (want.status) pool_full_stores++;
                expected_results.push_back(want);
            end
            pending = expected_results.size();
        end
    end

endmodule

// ===== tb/fixed_depth_radix_map_core_test.sv =====
// Top of the radix map core testbench: clock, reset, directed and random traffic
// with varying handshake pressure, and the verdict.
// Depends on fdrm_pkg, fixed_depth_radix_map_core and fdrm_map_checker.
module fixed_depth_radix_map_core_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned NODE_BITS   = 9;
    localparam int unsigned CYCLE_LIMIT = 1_000_000;
    localparam int unsigned KPW         = fdrm_pkg::KEY_PORT_W;
    localparam int unsigned VPW         = fdrm_pkg::VAL_PORT_W;

    logic                          aclk;
    logic                          aresetn;
    logic                          s_valid;
    logic                          s_ready;
    logic [fdrm_pkg::OP_W-1:0]     s_op;
    logic [KPW-1:0]                s_key;
    logic [VPW-1:0]                s_value;
    logic                          m_valid;
    logic                          m_ready;
    logic                          m_status;
    logic                          m_found;
    logic [VPW-1:0]                m_read_value;

    int unsigned mismatches;
    int unsigned results_checked;
    int unsigned lookup_hits;
    int unsigned pool_full_stores;
    int unsigned pending;
    int unsigned sender_idle_pct;
    int unsigned receiver_stall_pct;
    int unsigned transactions_sent;
    int unsigned cycle_count;

    logic [NODE_BITS-1:0] top_slices  [6];
    logic [NODE_BITS-1:0] mid_slices  [3];
    logic [NODE_BITS-1:0] low_slices  [3];
    logic [NODE_BITS-1:0] leaf_slices [4];

    fixed_depth_radix_map_core u_dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_op         (s_op),
        .s_key        (s_key),
        .s_value      (s_value),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_status     (m_status),
        .m_found      (m_found),
        .m_read_value (m_read_value)
    );

    fdrm_map_checker u_checker (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_op             (s_op),
        .s_key            (s_key),
        .s_value          (s_value),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_status         (m_status),
        .m_found          (m_found),
        .m_read_value     (m_read_value),
        .mismatches       (mismatches),
        .results_checked  (results_checked),
        .lookup_hits      (lookup_hits),
        .pool_full_stores (pool_full_stores),
        .pending          (pending)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("CHECKS FAILED");
        $finish;
    end

    initial begin
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            m_ready = ($urandom_range(99) >= receiver_stall_pct);
        end
    end

    task automatic send_item(fdrm_pkg::op_t op, logic [KPW-1:0] key,
                             logic [VPW-1:0] value);
        while ($urandom_range(99) < sender_idle_pct) begin
            s_valid = 1'b0;
            @(negedge aclk);
        end
        s_valid = 1'b1;
        s_op    = op;
        s_key   = key;
        s_value = value;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
        transactions_sent++;
    endtask

    task automatic wait_drained();
        s_valid = 1'b0;
        while (pending != 0) @(negedge aclk);
    endtask

    function automatic logic [VPW-1:0] random_value();
        logic [63:0] raw;
        raw = {$urandom, $urandom};
        unique case ($urandom_range(9))
            0:       return '0;
            1:       return '1;
            default: return raw[VPW-1:0];
        endcase
    endfunction

    function automatic logic [KPW-1:0] random_key();
        logic [63:0] raw;
        raw = {$urandom, $urandom};
        if ($urandom_range(99) < 5) return raw[KPW-1:0];
        return {top_slices[$urandom_range(5)], mid_slices[$urandom_range(2)],
                low_slices[$urandom_range(2)], leaf_slices[$urandom_range(3)]};
    endfunction

    function automatic fdrm_pkg::op_t random_op();
        int unsigned pick;
        pick = $urandom_range(99);
        if (pick < 40) return fdrm_pkg::OP_GET;
        if (pick < 80) return fdrm_pkg::OP_ADD;
        if (pick < 92) return fdrm_pkg::OP_DELETE;
        return fdrm_pkg::OP_NONE;
    endfunction

    task automatic run_phase(int unsigned count, int unsigned idle_pct, int unsigned stall_pct);
        sender_idle_pct    = idle_pct;
        receiver_stall_pct = stall_pct;
        repeat (count) send_item(random_op(), random_key(), random_value());
        wait_drained();
    endtask

    initial begin
        aresetn            = 1'b0;
        s_valid            = 1'b0;
        s_op               = fdrm_pkg::OP_GET;
        s_key              = '0;
        s_value            = '0;
        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
        transactions_sent  = 0;
        foreach (top_slices[i])  top_slices[i]  = NODE_BITS'($urandom);
        foreach (mid_slices[i])  mid_slices[i]  = NODE_BITS'($urandom);
        foreach (low_slices[i])  low_slices[i]  = NODE_BITS'($urandom);
        foreach (leaf_slices[i]) leaf_slices[i] = NODE_BITS'($urandom);
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        send_item(fdrm_pkg::OP_GET, 36'h0, 48'h0);
        send_item(fdrm_pkg::OP_GET, '1, '1);
        send_item(fdrm_pkg::OP_ADD, 36'h0, '1);
        send_item(fdrm_pkg::OP_GET, 36'h0, 48'h0);
        send_item(fdrm_pkg::OP_ADD, '1, 48'h1);
        send_item(fdrm_pkg::OP_GET, '1, 48'h0);
        send_item(fdrm_pkg::OP_ADD, 36'h0, 48'h0);
        send_item(fdrm_pkg::OP_GET, 36'h0, 48'h0);
        send_item(fdrm_pkg::OP_DELETE, '1, '1);
        send_item(fdrm_pkg::OP_GET, '1, 48'h0);
        send_item(fdrm_pkg::OP_DELETE, 36'h5_5555_5555, 48'h0);
        send_item(fdrm_pkg::OP_GET, 36'h5_5555_5555, 48'h0);
        send_item(fdrm_pkg::OP_NONE, 36'hA_AAAA_AAAA, 48'hAAAA_AAAA_AAAA);
        send_item(fdrm_pkg::OP_NONE, '1, '1);
        send_item(fdrm_pkg::OP_ADD, 36'h1, 48'hAAAA_AAAA_AAAA);
        send_item(fdrm_pkg::OP_GET, 36'h1, 48'h0);
        send_item(fdrm_pkg::OP_GET, 36'h2, 48'h0);
        send_item(fdrm_pkg::OP_GET, 36'h0_0004_0000, 48'h0);
        send_item(fdrm_pkg::OP_ADD, 36'h1, 48'h5555_5555_5555);
        send_item(fdrm_pkg::OP_GET, 36'h1, 48'h0);
        wait_drained();

        run_phase(150, 0, 0);
        run_phase(150, 85, 0);
        run_phase(150, 0, 85);
        run_phase(150, 20, 20);
        run_phase(100, 0, 0);
        repeat (20) @(negedge aclk);

        $display("Sent %0d transactions: directed corners, then five random pressure mixes.",
                 transactions_sent);
        $display("Checked %0d results, %0d lookup hits, %0d stores refused by a full pool.",
                 results_checked, lookup_hits, pool_full_stores);
        if (mismatches == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
